[rtl/bcdsu_pkg.sv]
// Shared types and constants for the bit count and double shift unit.
`timescale 1ns / 1ps
`default_nettype none
package bcdsu_pkg;

    localparam int unsigned DATA_W  = 64;
    localparam int unsigned HALF_W  = 32;
    localparam int unsigned OP_W    = 3;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned FLAGS_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_SHLD   = 3'd0,
        OP_SHRD   = 3'd1,
        OP_POPCNT = 3'd2,
        OP_LZCNT  = 3'd3,
        OP_TZCNT  = 3'd4
    } t_op;

    localparam logic [FLAGS_W-1:0] FLAG_CF = 32'h0000_0001;
    localparam logic [FLAGS_W-1:0] FLAG_PF = 32'h0000_0004;
    localparam logic [FLAGS_W-1:0] FLAG_AF = 32'h0000_0010;
    localparam logic [FLAGS_W-1:0] FLAG_ZF = 32'h0000_0040;
    localparam logic [FLAGS_W-1:0] FLAG_SF = 32'h0000_0080;
    localparam logic [FLAGS_W-1:0] FLAG_OF = 32'h0000_0800;

    localparam logic [FLAGS_W-1:0] POPCNT_CLR =
        FLAG_CF | FLAG_PF | FLAG_AF | FLAG_ZF | FLAG_SF | FLAG_OF;
    localparam logic [FLAGS_W-1:0] BITCNT_CLR = FLAG_CF | FLAG_ZF;

endpackage
`default_nettype wire

[rtl/bcdsu_in_if.sv]
// Request channel: operation, operands, count and incoming flags.
`timescale 1ns / 1ps
`default_nettype none
interface bcdsu_in_if import bcdsu_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic               wide;
    logic [DATA_W-1:0]  dest_value;
    logic [DATA_W-1:0]  source_value;
    logic [COUNT_W-1:0] shift_count;
    logic [FLAGS_W-1:0] flags_in;

    modport source (
        output valid, operation, wide, dest_value, source_value, shift_count, flags_in,
        input  ready
    );
    modport sink (
        input  valid, operation, wide, dest_value, source_value, shift_count, flags_in,
        output ready
    );
endinterface
`default_nettype wire

[rtl/bcdsu_out_if.sv]
// Response channel: result value, write enable and new flags.
`timescale 1ns / 1ps
`default_nettype none
interface bcdsu_out_if import bcdsu_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  result_value;
    logic               write_result;
    logic [FLAGS_W-1:0] flags_out;

    modport source (
        output valid, result_value, write_result, flags_out,
        input  ready
    );
    modport sink (
        input  valid, result_value, write_result, flags_out,
        output ready
    );
endinterface
`default_nettype wire

[rtl/bit_count_and_double_shift_unit_top.sv]
// A request passes through three register stages from request accept to response valid.
// Throughput: one request per cycle unless stalled; the 128-bit shift window (byte step,
// then bit step) and the byte-wise counters (per-byte stats, combine) each span two stages.
// A stalled response holds every full stage; ready propagates back through the valid bits.
// Reset clears the stage valid bits only; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module bit_count_and_double_shift_unit_top import bcdsu_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    bcdsu_in_if.sink    i_req,
    bcdsu_out_if.source o_rsp
);

    function automatic logic [DATA_W-1:0] bit_rev(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        for (int i = 0; i < DATA_W; i++) begin
            r[i] = v[DATA_W-1-i];
        end
        return r;
    endfunction

    function automatic logic [3:0] byte_ones(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'd0, b[i]};
        end
        return n;
    endfunction

    function automatic logic [2:0] byte_tz(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (b[i]) begin
                n = 3'(i);
            end
        end
        return n;
    endfunction

    // Stage enables
    logic en1, en2, en3;

    // Stage 1 registers
    logic               r1_v;
    t_op                r1_op;
    logic               r1_wide;
    logic [127:0]       r1_w;
    logic [6:0]         r1_base;
    logic [FLAGS_W-1:0] r1_flags;
    logic               r1_src_zero;
    logic               r1_cnt_nz;

    // Stage 2 registers
    logic               r2_v;
    t_op                r2_op;
    logic               r2_wide;
    logic [70:0]        r2_coarse;
    logic [2:0]         r2_fine;
    logic [FLAGS_W-1:0] r2_flags;
    logic               r2_src_zero;
    logic               r2_cnt_nz;
    logic [3:0]         r2_pop [8];
    logic [2:0]         r2_tz  [8];
    logic [7:0]         r2_nz;

    // Stage 3 (output) registers
    logic               r3_v;
    logic [DATA_W-1:0]  r3_res;
    logic               r3_wr;
    logic [FLAGS_W-1:0] r3_flags;

    assign en3 = !r3_v || o_rsp.ready;
    assign en2 = !r2_v || en3;
    assign en1 = !r1_v || en2;
    assign i_req.ready = en1;

    // ---------------- stage 1: truncate, build shift window ----------------
    logic [HALF_W-1:0]  d32, s32;
    logic [DATA_W-1:0]  src_t;
    logic [5:0]         cnt_m;
    t_op                op_in;
    logic [127:0]       n1_w;
    logic [6:0]         n1_base;

    assign d32   = i_req.dest_value[HALF_W-1:0];
    assign s32   = i_req.source_value[HALF_W-1:0];
    assign src_t = i_req.wide ? i_req.source_value : {32'd0, s32};
    assign cnt_m = i_req.wide ? i_req.shift_count[5:0] : {1'b0, i_req.shift_count[4:0]};
    assign op_in = t_op'(i_req.operation);

    always_comb begin
        n1_w    = '0;
        n1_base = 7'd0;
        case (op_in)
            OP_SHLD: begin
                // result is the top operand-size bits of {dest, src} << count
                n1_w    = i_req.wide ? {i_req.dest_value, i_req.source_value}
                                     : {64'd0, d32, s32};
                n1_base = (i_req.wide ? 7'd64 : 7'd32) - {1'b0, cnt_m};
            end
            OP_SHRD: begin
                n1_w    = i_req.wide ? {i_req.source_value, i_req.dest_value}
                                     : {64'd0, s32, d32};
                n1_base = {1'b0, cnt_m};
            end
            OP_POPCNT: begin
                n1_w = {64'd0, src_t};
            end
            OP_TZCNT: begin
                // a sentinel above a narrow operand stops the count at 32
                n1_w = {64'd0, i_req.wide ? i_req.source_value : {31'd0, 1'b1, s32}};
            end
            OP_LZCNT: begin
                n1_w = {64'd0, bit_rev(i_req.wide ? i_req.source_value
                                                  : {s32, 1'b1, 31'd0})};
            end
            default: begin
                n1_w    = '0;
                n1_base = 7'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en1) begin
            r1_v <= i_req.valid;
        end
        if (en1) begin
            r1_op       <= op_in;
            r1_wide     <= i_req.wide;
            r1_w        <= n1_w;
            r1_base     <= n1_base;
            r1_flags    <= i_req.flags_in;
            r1_src_zero <= (src_t == '0);
            r1_cnt_nz   <= (cnt_m != 6'd0);
        end
    end

    // ---------------- stage 2: byte shift, per-byte statistics ----------------
    logic [127:0] coarse_full;
    assign coarse_full = r1_w >> {r1_base[6:3], 3'b000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en2) begin
            r2_v <= r1_v;
        end
        if (en2) begin
            r2_op       <= r1_op;
            r2_wide     <= r1_wide;
            r2_coarse   <= coarse_full[70:0];
            r2_fine     <= r1_base[2:0];
            r2_flags    <= r1_flags;
            r2_src_zero <= r1_src_zero;
            r2_cnt_nz   <= r1_cnt_nz;
            for (int i = 0; i < 8; i++) begin
                r2_pop[i] <= byte_ones(r1_w[i*8 +: 8]);
                r2_tz[i]  <= byte_tz(r1_w[i*8 +: 8]);
                r2_nz[i]  <= (r1_w[i*8 +: 8] != 8'd0);
            end
        end
    end

    // ---------------- stage 3: bit shift, combine counts, flags ----------------
    logic [70:0]        fine_sh;
    logic [DATA_W-1:0]  shift_res;
    logic [6:0]         pop_sum;
    logic [6:0]         zcnt;
    logic [DATA_W-1:0]  n3_res;
    logic               n3_wr;
    logic [FLAGS_W-1:0] n3_flags;

    assign fine_sh   = r2_coarse >> r2_fine;
    assign shift_res = r2_wide ? fine_sh[63:0] : {32'd0, fine_sh[31:0]};

    always_comb begin
        pop_sum = 7'd0;
        for (int i = 0; i < 8; i++) begin
            pop_sum = pop_sum + {3'd0, r2_pop[i]};
        end
        // lowest nonzero byte wins; all-zero means the full 64
        zcnt = 7'd64;
        for (int i = 7; i >= 0; i--) begin
            if (r2_nz[i]) begin
                zcnt = {1'b0, 3'(i), r2_tz[i]};
            end
        end
    end

    always_comb begin
        n3_res   = '0;
        n3_wr    = 1'b0;
        n3_flags = r2_flags;
        case (r2_op)
            OP_SHLD, OP_SHRD: begin
                n3_res = shift_res;
                n3_wr  = r2_cnt_nz;
            end
            OP_POPCNT: begin
                n3_res   = {57'd0, pop_sum};
                n3_wr    = 1'b1;
                n3_flags = (r2_flags & ~POPCNT_CLR) | ((pop_sum == 7'd0) ? FLAG_ZF : '0);
            end
            OP_LZCNT, OP_TZCNT: begin
                n3_res   = {57'd0, zcnt};
                n3_wr    = 1'b1;
                n3_flags = (r2_flags & ~BITCNT_CLR)
                         | (r2_src_zero ? FLAG_CF : '0)
                         | ((zcnt == 7'd0) ? FLAG_ZF : '0);
            end
            default: begin
                n3_res   = '0;
                n3_wr    = 1'b0;
                n3_flags = r2_flags;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en3) begin
            r3_v <= r2_v;
        end
        if (en3) begin
            r3_res   <= n3_res;
            r3_wr    <= n3_wr;
            r3_flags <= n3_flags;
        end
    end

    assign o_rsp.valid        = r3_v;
    assign o_rsp.result_value = r3_res;
    assign o_rsp.write_result = r3_wr;
    assign o_rsp.flags_out    = r3_flags;

    // ---------------- assertions ----------------
    logic       in_acc, out_acc;
    logic [1:0] occ;
    assign in_acc  = i_req.valid && i_req.ready;
    assign out_acc = o_rsp.valid && o_rsp.ready;
    assign occ     = 2'($countones({r1_v, r2_v, r3_v}));

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> 3'(occ) == 3'($past(occ)) + 3'($past(in_acc)) - 3'($past(out_acc)))
        else $error("pipeline occupancy does not match accepted and delivered requests");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r1_v)
        else $error("accepted request did not enter stage 1");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_v && !o_rsp.ready |=> r3_v && $stable(r3_res) && $stable(r3_flags))
        else $error("stalled response was lost or changed");

    a_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !r1_v && !r2_v && !r3_v)
        else $error("stage valid bits set after reset");

endmodule
`default_nettype wire
